### hw/rtl/hsl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSL to RGB converter package
// Shared widths, scale constants, hue sector codes and the command record
// that travels from the front end through the queue to the back end.
// ----------------------------------------------------------------------------
package hsl_pkg;

   localparam int HUE_W  = 9;
   localparam int SAT_W  = 8;
   localparam int LIT_W  = 8;
   localparam int CHAN_W = 8;

   localparam int A_W    = 8;
   localparam int B_W    = 6;
   localparam int AS_W   = 16;
   localparam int LT_W   = 23;
   localparam int TERM_W = 23;
   localparam int SUM_W  = 24;

   localparam int LIGHT_SCALE = 30600;
   localparam int C_SCALE     = 120;
   localparam int M_SCALE     = 60;
   localparam int LIGHT_FULL  = 255;

   localparam int DIV_SHIFT   = 3;
   localparam int DIV_CORE    = 3825;
   localparam int CORE_W      = SUM_W - DIV_SHIFT;
   localparam int RECIP_SHIFT = 32;
   localparam int RECIP_W     = 21;
   localparam int PROD_W      = CORE_W + RECIP_W;
   localparam int QUO_W       = PROD_W - RECIP_SHIFT;
   localparam int REM_W       = 13;
   localparam int CHAN_MAX    = 255;

   localparam logic [RECIP_W-1:0] RECIP_K =
      RECIP_W'((longint'(1) <<< RECIP_SHIFT) / DIV_CORE);

   localparam logic [HUE_W-1:0] HUE_60  = 9'd60;
   localparam logic [HUE_W-1:0] HUE_120 = 9'd120;
   localparam logic [HUE_W-1:0] HUE_180 = 9'd180;
   localparam logic [HUE_W-1:0] HUE_240 = 9'd240;
   localparam logic [HUE_W-1:0] HUE_300 = 9'd300;
   localparam logic [HUE_W-1:0] HUE_360 = 9'd360;
   localparam logic [HUE_W-1:0] HUE_480 = 9'd480;

   localparam int QUEUE_DEPTH = 4;
   localparam int BACK_STAGES = 7;

   typedef enum logic [2:0] {
      SECTOR_RED_YELLOW    = 3'd0,
      SECTOR_YELLOW_GREEN  = 3'd1,
      SECTOR_GREEN_CYAN    = 3'd2,
      SECTOR_CYAN_BLUE     = 3'd3,
      SECTOR_BLUE_MAGENTA  = 3'd4,
      SECTOR_MAGENTA_RED   = 3'd5
   } sector_type;

   typedef struct packed {
      sector_type         sector;
      logic [A_W-1:0]     a;
      logic [B_W-1:0]     b;
      logic [SAT_W-1:0]   s;
      logic [LIT_W-1:0]   l;
   } cmd_type;

endpackage

### hw/rtl/hsl_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSL request channel
// Valid/ready channel that carries one pixel in hue, saturation, lightness.
// ----------------------------------------------------------------------------
interface hsl_req_if;
   logic                           valid;
   logic                           ready;
   logic [hsl_pkg::HUE_W-1:0]      hue;
   logic [hsl_pkg::SAT_W-1:0]      saturation;
   logic [hsl_pkg::LIT_W-1:0]      lightness;

   modport source (output valid, output hue, output saturation, output lightness,
                   input ready);
   modport sink   (input valid, input hue, input saturation, input lightness,
                   output ready);
endinterface

### hw/rtl/hsl_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB response channel
// Valid/ready channel that carries one pixel in red, green, blue.
// ----------------------------------------------------------------------------
interface hsl_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [hsl_pkg::CHAN_W-1:0]     red;
   logic [hsl_pkg::CHAN_W-1:0]     green;
   logic [hsl_pkg::CHAN_W-1:0]     blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

### hw/rtl/hsl_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSL front end
// Accepts request transactions, picks the hue sector and forms the
// lightness and hue distance terms, held in one register stage.
// ----------------------------------------------------------------------------
module hsl_front (
   input  logic              clock,
   input  logic              reset,
   hsl_req_if.sink           req_port,
   output hsl_pkg::cmd_type  cmd_data,
   output logic              cmd_valid,
   input  logic              cmd_ready
);

   logic                        vld_ff;
   logic                        vld_in;
   hsl_pkg::cmd_type            cmd_ff;
   hsl_pkg::cmd_type            cmd_in;
   logic                        take;
   logic [hsl_pkg::HUE_W-1:0]   hue;
   logic [hsl_pkg::HUE_W-1:0]   hue_mod;
   logic [hsl_pkg::HUE_W-1:0]   twol;
   logic [hsl_pkg::HUE_W-1:0]   spread;

   assign req_port.ready = !vld_ff || cmd_ready;
   assign take           = req_port.valid && req_port.ready;
   assign hue            = req_port.hue;

   always_comb begin
      if (hue >= hsl_pkg::HUE_480) begin
         hue_mod = hue - hsl_pkg::HUE_480;
      end else if (hue >= hsl_pkg::HUE_360) begin
         hue_mod = hue - hsl_pkg::HUE_360;
      end else if (hue >= hsl_pkg::HUE_240) begin
         hue_mod = hue - hsl_pkg::HUE_240;
      end else if (hue >= hsl_pkg::HUE_120) begin
         hue_mod = hue - hsl_pkg::HUE_120;
      end else begin
         hue_mod = hue;
      end

      twol = {req_port.lightness, 1'b0};
      if (twol >= hsl_pkg::HUE_W'(hsl_pkg::LIGHT_FULL)) begin
         spread = twol - hsl_pkg::HUE_W'(hsl_pkg::LIGHT_FULL);
      end else begin
         spread = hsl_pkg::HUE_W'(hsl_pkg::LIGHT_FULL) - twol;
      end

      cmd_in.a = hsl_pkg::A_W'(hsl_pkg::HUE_W'(hsl_pkg::LIGHT_FULL) - spread);
      if (hue_mod >= hsl_pkg::HUE_60) begin
         cmd_in.b = hsl_pkg::B_W'(hsl_pkg::HUE_120 - hue_mod);
      end else begin
         cmd_in.b = hsl_pkg::B_W'(hue_mod);
      end
      cmd_in.s = req_port.saturation;
      cmd_in.l = req_port.lightness;

      if (hue < hsl_pkg::HUE_60) begin
         cmd_in.sector = hsl_pkg::SECTOR_RED_YELLOW;
      end else if (hue < hsl_pkg::HUE_120) begin
         cmd_in.sector = hsl_pkg::SECTOR_YELLOW_GREEN;
      end else if (hue < hsl_pkg::HUE_180) begin
         cmd_in.sector = hsl_pkg::SECTOR_GREEN_CYAN;
      end else if (hue < hsl_pkg::HUE_240) begin
         cmd_in.sector = hsl_pkg::SECTOR_CYAN_BLUE;
      end else if (hue < hsl_pkg::HUE_300) begin
         cmd_in.sector = hsl_pkg::SECTOR_BLUE_MAGENTA;
      end else begin
         cmd_in.sector = hsl_pkg::SECTOR_MAGENTA_RED;
      end

      if (take) begin
         vld_in = 1'b1;
      end else if (cmd_ready) begin
         vld_in = 1'b0;
      end else begin
         vld_in = vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         cmd_ff <= cmd_in;
      end
   end

   assign cmd_valid = vld_ff;
   assign cmd_data  = cmd_ff;

endmodule

### hw/rtl/hsl_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSL command queue
// Small first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module hsl_queue #(
   parameter int DEPTH = hsl_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  hsl_pkg::cmd_type  in_data,
   input  logic              in_valid,
   output logic              in_ready,
   output hsl_pkg::cmd_type  out_data,
   output logic              out_valid,
   input  logic              out_ready
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   hsl_pkg::cmd_type    slot_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                push;
   logic                pop;

   assign in_ready  = count_ff != CNT_FULL;
   assign out_valid = count_ff != '0;
   assign out_data  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

### hw/rtl/hsl_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSL back end
// Pipelined chroma, second component and offset terms, division by the
// common scale through a reciprocal with one correction, sector routing and
// the output register.
// ----------------------------------------------------------------------------
module hsl_back (
   input  logic              clock,
   input  logic              reset,
   input  hsl_pkg::cmd_type  cmd_data,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   hsl_rsp_if.source         rsp_port
);

   localparam int STAGES = hsl_pkg::BACK_STAGES;
   localparam int LANES  = 3;
   localparam int LANE_C = 0;
   localparam int LANE_X = 1;
   localparam int LANE_M = 2;

   logic [STAGES-1:0]  vld_ff, vld_in;
   logic [STAGES-1:0]  en;

   hsl_pkg::sector_type sec_ff [STAGES-1];

   logic [hsl_pkg::AS_W-1:0]    as1_ff;
   logic [hsl_pkg::LT_W-1:0]    lt1_ff;
   logic [hsl_pkg::B_W-1:0]     b1_ff;

   logic [hsl_pkg::TERM_W-1:0]  cn2_ff, xn2_ff, as60_2_ff;
   logic [hsl_pkg::LT_W-1:0]    lt2_ff;

   logic [hsl_pkg::TERM_W-1:0]  cn3_ff, xn3_ff, mn3_ff;

   logic [hsl_pkg::CORE_W-1:0]  core4_ff [LANES];
   logic [hsl_pkg::SUM_W-1:0]   sum4 [LANES];

   logic [hsl_pkg::CORE_W-1:0]  core5_ff [LANES];
   logic [hsl_pkg::QUO_W-1:0]   quo5_ff [LANES];
   logic [hsl_pkg::PROD_W-1:0]  prod5 [LANES];

   logic [hsl_pkg::QUO_W-1:0]   quo6_ff [LANES];
   logic [hsl_pkg::REM_W-1:0]   rem6_ff [LANES];
   logic [hsl_pkg::CORE_W-1:0]  back6 [LANES];
   logic [hsl_pkg::CORE_W-1:0]  diff6 [LANES];

   logic [hsl_pkg::QUO_W-1:0]   quo7 [LANES];
   logic [hsl_pkg::CHAN_W-1:0]  chan7 [LANES];
   logic [hsl_pkg::CHAN_W-1:0]  red_ff, green_ff, blue_ff;
   logic [hsl_pkg::CHAN_W-1:0]  red_in, green_in, blue_in;

   always_comb begin
      en[STAGES-1] = !vld_ff[STAGES-1] || rsp_port.ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
      vld_in[0] = en[0] ? cmd_valid : vld_ff[0];
      for (int k = 1; k < STAGES; k++) begin
         vld_in[k] = en[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   assign cmd_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         sec_ff[0] <= cmd_data.sector;
      end
      for (int k = 1; k < STAGES - 1; k++) begin
         if (en[k]) begin
            sec_ff[k] <= sec_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         as1_ff <= hsl_pkg::AS_W'(cmd_data.a) * hsl_pkg::AS_W'(cmd_data.s);
         lt1_ff <= hsl_pkg::LT_W'(cmd_data.l) * hsl_pkg::LT_W'(hsl_pkg::LIGHT_SCALE);
         b1_ff  <= cmd_data.b;
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         cn2_ff    <= hsl_pkg::TERM_W'(as1_ff) * hsl_pkg::TERM_W'(hsl_pkg::C_SCALE);
         xn2_ff    <= hsl_pkg::TERM_W'(as1_ff) * hsl_pkg::TERM_W'({b1_ff, 1'b0});
         as60_2_ff <= hsl_pkg::TERM_W'(as1_ff) * hsl_pkg::TERM_W'(hsl_pkg::M_SCALE);
         lt2_ff    <= lt1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         cn3_ff <= cn2_ff;
         xn3_ff <= xn2_ff;
         mn3_ff <= lt2_ff - as60_2_ff;
      end
   end

   always_comb begin
      sum4[LANE_C] = hsl_pkg::SUM_W'(cn3_ff) + hsl_pkg::SUM_W'(mn3_ff);
      sum4[LANE_X] = hsl_pkg::SUM_W'(xn3_ff) + hsl_pkg::SUM_W'(mn3_ff);
      sum4[LANE_M] = hsl_pkg::SUM_W'(mn3_ff);
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         for (int i = 0; i < LANES; i++) begin
            core4_ff[i] <= sum4[i][hsl_pkg::SUM_W-1:hsl_pkg::DIV_SHIFT];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         prod5[i] = hsl_pkg::PROD_W'(core4_ff[i]) * hsl_pkg::PROD_W'(hsl_pkg::RECIP_K);
      end
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         for (int i = 0; i < LANES; i++) begin
            core5_ff[i] <= core4_ff[i];
            quo5_ff[i]  <= prod5[i][hsl_pkg::PROD_W-1:hsl_pkg::RECIP_SHIFT];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         back6[i] = hsl_pkg::CORE_W'(quo5_ff[i]) * hsl_pkg::CORE_W'(hsl_pkg::DIV_CORE);
         diff6[i] = core5_ff[i] - back6[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         for (int i = 0; i < LANES; i++) begin
            quo6_ff[i] <= quo5_ff[i];
            rem6_ff[i] <= diff6[i][hsl_pkg::REM_W-1:0];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         if (rem6_ff[i] >= hsl_pkg::REM_W'(hsl_pkg::DIV_CORE)) begin
            quo7[i] = quo6_ff[i] + 1'b1;
         end else begin
            quo7[i] = quo6_ff[i];
         end
         if (quo7[i] > hsl_pkg::QUO_W'(hsl_pkg::CHAN_MAX)) begin
            chan7[i] = hsl_pkg::CHAN_W'(hsl_pkg::CHAN_MAX);
         end else begin
            chan7[i] = quo7[i][hsl_pkg::CHAN_W-1:0];
         end
      end

      case (sec_ff[STAGES-2])
         hsl_pkg::SECTOR_RED_YELLOW: begin
            red_in = chan7[LANE_C]; green_in = chan7[LANE_X]; blue_in = chan7[LANE_M];
         end
         hsl_pkg::SECTOR_YELLOW_GREEN: begin
            red_in = chan7[LANE_X]; green_in = chan7[LANE_C]; blue_in = chan7[LANE_M];
         end
         hsl_pkg::SECTOR_GREEN_CYAN: begin
            red_in = chan7[LANE_M]; green_in = chan7[LANE_C]; blue_in = chan7[LANE_X];
         end
         hsl_pkg::SECTOR_CYAN_BLUE: begin
            red_in = chan7[LANE_M]; green_in = chan7[LANE_X]; blue_in = chan7[LANE_C];
         end
         hsl_pkg::SECTOR_BLUE_MAGENTA: begin
            red_in = chan7[LANE_X]; green_in = chan7[LANE_M]; blue_in = chan7[LANE_C];
         end
         default: begin
            red_in = chan7[LANE_C]; green_in = chan7[LANE_M]; blue_in = chan7[LANE_X];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en[STAGES-1]) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign rsp_port.valid = vld_ff[STAGES-1];
   assign rsp_port.red   = red_ff;
   assign rsp_port.green = green_ff;
   assign rsp_port.blue  = blue_ff;

endmodule

### hw/rtl/hsl_to_rgb_converter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSL to RGB converter unit
// Converts one pixel from hue, saturation and lightness to 8-bit red, green
// and blue with exact integer arithmetic, truncated and clamped.
// ----------------------------------------------------------------------------
// The unit accepts one pixel transaction every clock cycle while the result
// side does not stall, and returns one RGB transaction per pixel, in order.
// A pixel passes the front register, then the command queue and then the
// seven back-end stages, whose reciprocal multiply and remainder correction
// set that depth, the last of them being the output register. The queue,
// QUEUE_DEPTH entries deep, absorbs stalls on the result side, and the
// request side keeps accepting until the front, queue and pipeline are
// all full.
module hsl_to_rgb_converter_unit #(
   parameter int QUEUE_DEPTH = hsl_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   hsl_req_if.sink     req_port,
   hsl_rsp_if.source   rsp_port
);

   hsl_pkg::cmd_type  front_data;
   logic              front_valid;
   logic              front_ready;
   hsl_pkg::cmd_type  queue_data;
   logic              queue_valid;
   logic              queue_ready;

   hsl_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_port  (req_port),
      .cmd_data  (front_data),
      .cmd_valid (front_valid),
      .cmd_ready (front_ready)
   );

   hsl_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_data   (front_data),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .out_data  (queue_data),
      .out_valid (queue_valid),
      .out_ready (queue_ready)
   );

   hsl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_data  (queue_data),
      .cmd_valid (queue_valid),
      .cmd_ready (queue_ready),
      .rsp_port  (rsp_port)
   );

endmodule

### hw/rtl/hsl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSL to RGB converter checker
// Port-level checks on reset behavior, result hold and transaction balance.
// ----------------------------------------------------------------------------
module hsl_checker #(
   parameter int QUEUE_DEPTH = hsl_pkg::QUEUE_DEPTH
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [hsl_pkg::CHAN_W-1:0]    rsp_red,
   input logic [hsl_pkg::CHAN_W-1:0]    rsp_green,
   input logic [hsl_pkg::CHAN_W-1:0]    rsp_blue
);

   localparam int CAPACITY = 1 + QUEUE_DEPTH + hsl_pkg::BACK_STAGES;
   localparam int CNT_W    = $clog2(CAPACITY + 2);

   logic [CNT_W-1:0] pending_ff, pending_in;
   logic             req_take;
   logic             rsp_take;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff;
      if (req_take && !rsp_take) begin
         pending_in = pending_ff + 1'b1;
      end else if (rsp_take && !req_take && pending_ff != '0) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_reset_clears_result: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_result_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != '0)
      else $error("result shown with no pixel outstanding");

   a_capacity_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= CNT_W'(CAPACITY))
      else $error("more pixels outstanding than the unit can hold");

   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn before transaction");

   a_payload_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_red) && $stable(rsp_green) && $stable(rsp_blue))
      else $error("result payload changed while stalled");

endmodule

bind hsl_to_rgb_converter_unit hsl_checker #(
   .QUEUE_DEPTH (QUEUE_DEPTH)
) u_hsl_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_port.valid),
   .req_ready (req_port.ready),
   .rsp_valid (rsp_port.valid),
   .rsp_ready (rsp_port.ready),
   .rsp_red   (rsp_port.red),
   .rsp_green (rsp_port.green),
   .rsp_blue  (rsp_port.blue)
);
